/* hw/rtl/tpcq_pkg.sv */
// Shared types and constants of the two-priority command queue.
package tpcq_pkg;

    // Input command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Largest slot and byte-position index widths over the parameter range
    localparam int SLOT_W_MAX = 6;
    localparam int POS_W_MAX  = 6;
    localparam int LEN_OUT_W  = 6;
    localparam int TOTAL_W    = 5;

    // Job queue between front and back
    localparam int JOBQ_DEPTH = 4;
    localparam int JOBQ_PTR_W = 2;

    typedef enum logic [1:0] {
        KIND_PUSH_OK    = 2'd0,
        KIND_PUSH_FULL  = 2'd1,
        KIND_POP_DATA   = 2'd2,
        KIND_POP_EMPTY  = 2'd3
    } kind_t;

    // One unit of back-end work: a push result or a pop to stream
    typedef struct packed {
        kind_t                  kind;
        logic                   ring;
        logic [SLOT_W_MAX-1:0]  slot;
        logic [TOTAL_W-1:0]     total;
    } job_t;

    typedef struct packed {
        logic                   en;
        logic                   ring;
        logic [SLOT_W_MAX-1:0]  slot;
        logic [POS_W_MAX-1:0]   pos;
        logic [7:0]             data;
    } byte_wr_t;

    typedef struct packed {
        logic                   en;
        logic                   ring;
        logic [SLOT_W_MAX-1:0]  slot;
        logic [POS_W_MAX-1:0]   len;
    } len_wr_t;

    // One result item
    typedef struct packed {
        kind_t                  kind;
        logic [7:0]             data;
        logic                   byte_valid;
        logic                   ring;
        logic [LEN_OUT_W-1:0]   length;
        logic                   last;
        logic [TOTAL_W-1:0]     total;
    } res_t;

endpackage

/* hw/rtl/tpcq_front.sv */
// Front end: accepts commands, tracks ring pointers and push state, issues jobs.
module tpcq_front #(
    parameter int QUEUE_DEPTH = 8,
    parameter int ENTRY_BYTES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_cmd,
    input  logic                in_prio,
    input  logic [7:0]          in_byte,
    input  logic                in_present,
    input  logic                in_last,
    input  logic                fifo_full,
    output logic                job_valid,
    output tpcq_pkg::job_t      job,
    input  logic                pop_done,
    output tpcq_pkg::byte_wr_t  byte_wr,
    output tpcq_pkg::len_wr_t   len_wr
);

    localparam int SW  = $clog2(QUEUE_DEPTH);
    localparam int PW  = $clog2(ENTRY_BYTES);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int SWM = tpcq_pkg::SLOT_W_MAX;
    localparam int PWM = tpcq_pkg::POS_W_MAX;
    localparam int TW  = tpcq_pkg::TOTAL_W;
    localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] LAST_SLOT = SW'(QUEUE_DEPTH - 1);
    localparam logic [PW-1:0] POS_LIMIT = PW'(ENTRY_BYTES - 1);

    logic [SW-1:0] hi_rd_reg, hi_rd_next, hi_wr_reg, hi_wr_next;
    logic [SW-1:0] lo_rd_reg, lo_rd_next, lo_wr_reg, lo_wr_next;
    logic [CW-1:0] hi_cnt_reg, hi_cnt_next, lo_cnt_reg, lo_cnt_next;
    logic          push_active_reg, push_active_next;
    logic          push_ring_reg, push_ring_next;
    logic          push_drop_reg, push_drop_next;
    logic [PW-1:0] push_pos_reg, push_pos_next;
    logic          pop_pend_reg, pop_pend_next;

    logic          accept;
    logic          sel_ring, sel_drop, store;
    logic [CW-1:0] sel_cnt;
    logic [SW-1:0] sel_wr;
    logic [PW-1:0] sel_pos, pos_after;
    logic [CW:0]   total_now;

    assign in_ready = !fifo_full && !pop_pend_reg;
    assign accept   = in_valid && in_ready;

    always_comb begin
        total_now = {1'b0, hi_cnt_reg} + {1'b0, lo_cnt_reg};
        sel_ring  = push_active_reg ? push_ring_reg : in_prio;
        sel_cnt   = sel_ring ? hi_cnt_reg : lo_cnt_reg;
        sel_drop  = push_active_reg ? push_drop_reg : (sel_cnt >= DEPTH_C);
        sel_pos   = push_active_reg ? push_pos_reg : '0;
        sel_wr    = sel_ring ? hi_wr_reg : lo_wr_reg;
        store     = in_present && !sel_drop && (sel_pos < POS_LIMIT);
        pos_after = store ? sel_pos + PW'(1) : sel_pos;

        hi_rd_next       = hi_rd_reg;
        hi_wr_next       = hi_wr_reg;
        hi_cnt_next      = hi_cnt_reg;
        lo_rd_next       = lo_rd_reg;
        lo_wr_next       = lo_wr_reg;
        lo_cnt_next      = lo_cnt_reg;
        push_active_next = push_active_reg;
        push_ring_next   = push_ring_reg;
        push_drop_next   = push_drop_reg;
        push_pos_next    = push_pos_reg;
        pop_pend_next    = pop_pend_reg;
        job_valid        = 1'b0;
        job              = '0;
        byte_wr          = '0;
        len_wr           = '0;

        if (accept && in_cmd == tpcq_pkg::CMD_PUSH) begin
            byte_wr.en   = store;
            byte_wr.ring = sel_ring;
            byte_wr.slot = SWM'(sel_wr);
            byte_wr.pos  = PWM'(sel_pos);
            byte_wr.data = in_byte;
            if (in_last) begin
                push_active_next = 1'b0;
                push_drop_next   = 1'b0;
                push_pos_next    = '0;
                job_valid        = 1'b1;
                if (sel_drop) begin
                    job.kind  = tpcq_pkg::KIND_PUSH_FULL;
                    job.total = TW'(total_now);
                end else begin
                    len_wr.en   = 1'b1;
                    len_wr.ring = sel_ring;
                    len_wr.slot = SWM'(sel_wr);
                    len_wr.len  = PWM'(pos_after);
                    if (sel_ring) begin
                        hi_wr_next  = (hi_wr_reg == LAST_SLOT) ? '0 : hi_wr_reg + SW'(1);
                        hi_cnt_next = hi_cnt_reg + CW'(1);
                    end else begin
                        lo_wr_next  = (lo_wr_reg == LAST_SLOT) ? '0 : lo_wr_reg + SW'(1);
                        lo_cnt_next = lo_cnt_reg + CW'(1);
                    end
                    job.kind  = tpcq_pkg::KIND_PUSH_OK;
                    job.total = TW'(total_now + (CW+1)'(1));
                end
            end else begin
                // hold the latched ring and drop decision for the rest of the command
                push_active_next = 1'b1;
                push_ring_next   = sel_ring;
                push_drop_next   = sel_drop;
                push_pos_next    = pos_after;
            end
        end else if (accept) begin
            pop_pend_next = 1'b1;
            job_valid     = 1'b1;
            priority if (hi_cnt_reg != '0) begin
                job.kind    = tpcq_pkg::KIND_POP_DATA;
                job.ring    = 1'b1;
                job.slot    = SWM'(hi_rd_reg);
                job.total   = TW'(total_now - (CW+1)'(1));
                hi_rd_next  = (hi_rd_reg == LAST_SLOT) ? '0 : hi_rd_reg + SW'(1);
                hi_cnt_next = hi_cnt_reg - CW'(1);
            end else if (lo_cnt_reg != '0) begin
                job.kind    = tpcq_pkg::KIND_POP_DATA;
                job.ring    = 1'b0;
                job.slot    = SWM'(lo_rd_reg);
                job.total   = TW'(total_now - (CW+1)'(1));
                lo_rd_next  = (lo_rd_reg == LAST_SLOT) ? '0 : lo_rd_reg + SW'(1);
                lo_cnt_next = lo_cnt_reg - CW'(1);
            end else begin
                job.kind  = tpcq_pkg::KIND_POP_EMPTY;
                job.total = TW'(total_now);
            end
        end else if (pop_done) begin
            pop_pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_rd_reg       <= '0;
            hi_wr_reg       <= '0;
            hi_cnt_reg      <= '0;
            lo_rd_reg       <= '0;
            lo_wr_reg       <= '0;
            lo_cnt_reg      <= '0;
            push_active_reg <= 1'b0;
            push_ring_reg   <= 1'b0;
            push_drop_reg   <= 1'b0;
            push_pos_reg    <= '0;
            pop_pend_reg    <= 1'b0;
        end else begin
            hi_rd_reg       <= hi_rd_next;
            hi_wr_reg       <= hi_wr_next;
            hi_cnt_reg      <= hi_cnt_next;
            lo_rd_reg       <= lo_rd_next;
            lo_wr_reg       <= lo_wr_next;
            lo_cnt_reg      <= lo_cnt_next;
            push_active_reg <= push_active_next;
            push_ring_reg   <= push_ring_next;
            push_drop_reg   <= push_drop_next;
            push_pos_reg    <= push_pos_next;
            pop_pend_reg    <= pop_pend_next;
        end
    end

endmodule

/* hw/rtl/tpcq_job_fifo.sv */
// Short job queue between the front and back ends.
module tpcq_job_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  tpcq_pkg::job_t  wr_data,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output tpcq_pkg::job_t  rd_data
);

    localparam int PTRW = tpcq_pkg::JOBQ_PTR_W;
    localparam int DEP  = tpcq_pkg::JOBQ_DEPTH;

    tpcq_pkg::job_t  entry_reg [0:DEP-1];
    logic [PTRW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTRW:0]   count_reg, count_next;

    assign full     = (count_reg == (PTRW+1)'(DEP));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        unique case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + (PTRW+1)'(1);
            2'b01:   count_next = count_reg - (PTRW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + PTRW'(1);
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + PTRW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hw/rtl/tpcq_back.sv */
// Back end: entry stores, pop streaming and the result output register.
module tpcq_back #(
    parameter int QUEUE_DEPTH = 8,
    parameter int ENTRY_BYTES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    input  tpcq_pkg::job_t      job,
    output logic                job_rd,
    output logic                pop_done,
    input  tpcq_pkg::byte_wr_t  byte_wr,
    input  tpcq_pkg::len_wr_t   len_wr,
    output logic                out_valid,
    input  logic                out_ready,
    output tpcq_pkg::res_t      out_res
);

    localparam int SW        = $clog2(QUEUE_DEPTH);
    localparam int PW        = $clog2(ENTRY_BYTES);
    localparam int LOW       = tpcq_pkg::LEN_OUT_W;
    localparam int TW        = tpcq_pkg::TOTAL_W;
    localparam int BYTE_AW   = 1 + SW + PW;
    localparam int BYTE_DEP  = 2 ** BYTE_AW;
    localparam int LEN_DEP   = 2 ** (1 + SW);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LEN    = 3'b010,
        ST_STREAM = 3'b100
    } state_t;

    logic [7:0]    byte_mem [0:BYTE_DEP-1];
    logic [PW-1:0] len_mem  [0:LEN_DEP-1];

    state_t         state_reg, state_next;
    logic           cur_ring_reg;
    logic [SW-1:0]  cur_slot_reg;
    logic [TW-1:0]  cur_total_reg;
    logic [PW-1:0]  len_q_reg;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [7:0]     rd_data_reg;
    logic           s1_valid_reg;
    tpcq_pkg::res_t s1_reg, s1_new;
    logic           out_valid_reg;
    tpcq_pkg::res_t out_reg, out_new;

    logic out_free, s1_free, s1_load, rd_en, len_rd_en, is_last;

    assign out_free  = !out_valid_reg || out_ready;
    assign s1_free   = !s1_valid_reg || out_free;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign is_last   = (pos_reg == len_q_reg - PW'(1));

    // Merge the registered store byte into the staged result
    always_comb begin
        out_new      = s1_reg;
        out_new.data = s1_reg.byte_valid ? rd_data_reg : 8'h00;
    end

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        job_rd     = 1'b0;
        pop_done   = 1'b0;
        rd_en      = 1'b0;
        len_rd_en  = 1'b0;
        s1_load    = 1'b0;
        s1_new     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid && s1_free) begin
                    job_rd = 1'b1;
                    if (job.kind == tpcq_pkg::KIND_POP_DATA) begin
                        len_rd_en  = 1'b1;
                        state_next = ST_LEN;
                    end else begin
                        s1_load      = 1'b1;
                        s1_new.kind  = job.kind;
                        s1_new.last  = 1'b1;
                        s1_new.total = job.total;
                        pop_done     = (job.kind == tpcq_pkg::KIND_POP_EMPTY);
                    end
                end
            end
            ST_LEN: begin
                if (len_q_reg == '0) begin
                    if (s1_free) begin
                        s1_load      = 1'b1;
                        s1_new.kind  = tpcq_pkg::KIND_POP_DATA;
                        s1_new.ring  = cur_ring_reg;
                        s1_new.last  = 1'b1;
                        s1_new.total = cur_total_reg;
                        pop_done     = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    pos_next   = '0;
                    state_next = ST_STREAM;
                end
            end
            ST_STREAM: begin
                if (s1_free) begin
                    rd_en             = 1'b1;
                    s1_load           = 1'b1;
                    s1_new.kind       = tpcq_pkg::KIND_POP_DATA;
                    s1_new.byte_valid = 1'b1;
                    s1_new.ring       = cur_ring_reg;
                    s1_new.length     = LOW'(len_q_reg);
                    s1_new.last       = is_last;
                    s1_new.total      = cur_total_reg;
                    pos_next          = pos_reg + PW'(1);
                    if (is_last) begin
                        pop_done   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s1_load) begin
                s1_valid_reg <= 1'b1;
            end else if (out_free) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_valid_reg && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        if (s1_load) begin
            s1_reg <= s1_new;
        end
        if (s1_valid_reg && out_free) begin
            out_reg <= out_new;
        end
        if (len_rd_en) begin
            cur_ring_reg  <= job.ring;
            cur_slot_reg  <= job.slot[SW-1:0];
            cur_total_reg <= job.total;
        end
    end

    // Entry stores
    always_ff @(posedge aclk) begin
        if (byte_wr.en) begin
            byte_mem[{byte_wr.ring, byte_wr.slot[SW-1:0], byte_wr.pos[PW-1:0]}] <= byte_wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= byte_mem[{cur_ring_reg, cur_slot_reg, pos_reg}];
        end
    end

    always_ff @(posedge aclk) begin
        if (len_wr.en) begin
            len_mem[{len_wr.ring, len_wr.slot[SW-1:0]}] <= len_wr.len[PW-1:0];
        end
        if (len_rd_en) begin
            len_q_reg <= len_mem[{job.ring, job.slot[SW-1:0]}];
        end
    end

endmodule

/* hw/rtl/two_priority_command_queue.sv */
// Top level of the two-priority command queue: ports, field packing, front/back wiring.
//
// Two message rings (high and low priority), each holding QUEUE_DEPTH entries
// of up to ENTRY_BYTES-1 bytes. A push command streams in one byte per input
// transfer; its ring is latched on the first byte and the whole command is
// dropped if that ring is full then. Bytes past ENTRY_BYTES-1 are discarded.
// Only the transfer with s_tlast set produces a result (accepted or rejected).
// A pop takes the oldest high entry, else the oldest low entry, and streams its
// bytes out one result per byte (one result for an empty entry or empty rings).
// Rate: push bytes are taken one per cycle while s_tready is high. Push
// results pass through a four-job queue into the back end, which emits one
// result per cycle unless m_tready or a pop's length lookup holds it. A pop
// holds s_tready low from its own transfer until the back end is done with
// it: the last byte read of the entry is issued, or the single result of an
// empty entry or of a pop on empty rings is staged. Jobs queued ahead of it,
// output stalls and the single read port of the byte store set this wait.
// The output register and a staging register let the back end keep working
// while a finished result waits on m_tready.
module two_priority_command_queue #(
    parameter int QUEUE_DEPTH = 8,
    parameter int ENTRY_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [0] priority_req, [8:1] data_byte, [15:9] zero
    input  logic        s_tlast,   // last_byte
    input  logic [1:0]  s_tuser,   // [0] command, [1] byte_present
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte_res, [8] priority_res,
                                   // [14:9] length, [19:15] total_count, [23:20] zero
    output logic        m_tlast,   // last
    output logic [2:0]  m_tuser    // [1:0] kind, [2] byte_valid
);

    logic                fifo_full;
    logic                fifo_wr;
    logic                fifo_rd;
    logic                fifo_valid;
    logic                pop_done;
    tpcq_pkg::job_t      job_in;
    tpcq_pkg::job_t      job_out;
    tpcq_pkg::byte_wr_t  byte_wr;
    tpcq_pkg::len_wr_t   len_wr;
    tpcq_pkg::res_t      res;

    // Front: classify each transfer, update ring pointers, write the stores
    tpcq_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ENTRY_BYTES (ENTRY_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser[0]),
        .in_prio    (s_tdata[0]),
        .in_byte    (s_tdata[8:1]),
        .in_present (s_tuser[1]),
        .in_last    (s_tlast),
        .fifo_full  (fifo_full),
        .job_valid  (fifo_wr),
        .job        (job_in),
        .pop_done   (pop_done),
        .byte_wr    (byte_wr),
        .len_wr     (len_wr)
    );

    // Decouple front and back so each can stall on its own
    tpcq_job_fifo u_job_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (fifo_wr),
        .wr_data  (job_in),
        .full     (fifo_full),
        .rd_en    (fifo_rd),
        .rd_valid (fifo_valid),
        .rd_data  (job_out)
    );

    // Back: turn jobs into result transfers, streaming popped bytes
    tpcq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ENTRY_BYTES (ENTRY_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (fifo_valid),
        .job       (job_out),
        .job_rd    (fifo_rd),
        .pop_done  (pop_done),
        .byte_wr   (byte_wr),
        .len_wr    (len_wr),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Pack the result fields, lowest field first
    assign m_tdata = {4'b0000, res.total, res.length, res.ring, res.data};
    assign m_tlast = res.last;
    assign m_tuser = {res.byte_valid, res.kind};

endmodule
